### rtl/sliding_window_bitrate_meter_unit_macros.svh
// assertion macros for the sliding window bitrate meter
// expects clk and rst_n in the scope of use
`ifndef SLIDING_WINDOW_BITRATE_METER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_BITRATE_METER_UNIT_MACROS_SVH

// condition implies property in the same cycle
`define SWBM_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("swbm assertion failed");

// condition implies property in the next cycle
`define SWBM_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("swbm assertion failed");

`endif

### rtl/swbm_pkg.sv
// shared constants and types of the sliding window bitrate meter
// no dependencies
`default_nettype none

package swbm_pkg;

    localparam int WINDOW_DEPTH = 128;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;

    localparam int FPS_W        = 8;
    localparam int SIZE_W       = 24;
    localparam int COUNT_W      = 32;
    localparam int SUM_W        = 32;
    localparam int TOTAL_W      = 56;
    localparam int RATE_W       = 31;
    localparam int PROD_W       = TOTAL_W + FPS_W;
    localparam int QCNT_W       = $clog2(RATE_W);
    localparam int OUT_W        = 96;

    localparam logic [FPS_W-1:0]   FPS_RESET = 8'd25;
    localparam logic [RATE_W-1:0]  RATE_MAX  = {RATE_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // request to the shared multiply-divide unit
    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] operand;
        logic [FPS_W-1:0]   scale;
        logic [COUNT_W-1:0] divisor;
    } md_req_t;

    // status from the shared multiply-divide unit
    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quotient;
    } md_rsp_t;

endpackage

`default_nettype wire

### rtl/swbm_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module swbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/swbm_muldiv.sv
// shared multiply then restoring divide unit, saturating 31-bit quotient
// depends on swbm_pkg
`default_nettype none

module swbm_muldiv (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire swbm_pkg::md_req_t req,
    output swbm_pkg::md_rsp_t     rsp
);

    typedef enum logic [3:0] {
        MD_IDLE = 4'b0001,
        MD_MUL  = 4'b0010,
        MD_CHK  = 4'b0100,
        MD_DIV  = 4'b1000
    } md_state_t;

    md_state_t                          state_reg, state_next;
    logic [swbm_pkg::TOTAL_W-1:0]       op_reg, op_next;
    logic [swbm_pkg::FPS_W-1:0]         scale_reg, scale_next;
    logic [swbm_pkg::COUNT_W-1:0]       div_reg, div_next;
    logic [swbm_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic [swbm_pkg::COUNT_W-1:0]       rem_reg, rem_next;
    logic [swbm_pkg::RATE_W-1:0]        quo_reg, quo_next;
    logic [swbm_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;
    logic                               done_reg, done_next;
    logic [swbm_pkg::RATE_W-1:0]        result_reg, result_next;
    logic [swbm_pkg::COUNT_W:0]         top;
    logic [swbm_pkg::COUNT_W:0]         trial;
    logic [swbm_pkg::COUNT_W:0]         diff;
    logic                               qbit;

    assign top   = prod_reg[swbm_pkg::PROD_W-1:swbm_pkg::RATE_W];
    assign trial = {rem_reg, prod_reg[swbm_pkg::PROD_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign qbit  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        scale_next  = scale_reg;
        div_next    = div_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.operand;
                    scale_next = req.scale;
                    div_next   = req.divisor;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                prod_next  = swbm_pkg::PROD_W'(op_reg) * swbm_pkg::PROD_W'(scale_reg);
                state_next = MD_CHK;
            end
            MD_CHK:
            begin
                // quotient does not fit in 31 bits: saturate
                if (top >= {1'b0, div_reg})
                begin
                    result_next = swbm_pkg::RATE_MAX;
                    done_next   = 1'b1;
                    state_next  = MD_IDLE;
                end
                else
                begin
                    rem_next   = top[swbm_pkg::COUNT_W-1:0];
                    prod_next  = {prod_reg[swbm_pkg::RATE_W-1:0],
                                  {(swbm_pkg::PROD_W - swbm_pkg::RATE_W){1'b0}}};
                    quo_next   = '0;
                    cnt_next   = swbm_pkg::QCNT_W'(swbm_pkg::RATE_W - 1);
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                rem_next  = qbit ? diff[swbm_pkg::COUNT_W-1:0] : trial[swbm_pkg::COUNT_W-1:0];
                quo_next  = {quo_reg[swbm_pkg::RATE_W-2:0], qbit};
                prod_next = {prod_reg[swbm_pkg::PROD_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    result_next = {quo_reg[swbm_pkg::RATE_W-2:0], qbit};
                    done_next   = 1'b1;
                    state_next  = MD_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        scale_reg  <= scale_next;
        div_reg    <= div_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = result_reg;

endmodule

`default_nettype wire

### rtl/sliding_window_bitrate_meter_unit.sv
// sequence: the frame is accepted, its ring slots are swept and summed, then two multiply-divide
// passes run (window rate, then global rate; a pass ends early when it saturates), then the result load
// one frame at a time: busy until the result is registered
// reset: ring valid bits, counters and fps (25) clear at once, no clearing pass
// depends on swbm_pkg, swbm_ram, swbm_muldiv and the assertion macro header
`default_nettype none
`include "sliding_window_bitrate_meter_unit_macros.svh"

module sliding_window_bitrate_meter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,       // frames_per_second
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // frame_size[23:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [95:0] m_axis_tdata    // frame_number[31:0], window_rate[62:32],
                                             // global_rate[93:63], zero[95:94]
);

    typedef enum logic [6:0] {
        T_IDLE   = 7'b0000001,
        T_SWEEP  = 7'b0000010,
        T_WSTART = 7'b0000100,
        T_WWAIT  = 7'b0001000,
        T_GSTART = 7'b0010000,
        T_GWAIT  = 7'b0100000,
        T_OUT    = 7'b1000000
    } top_state_t;

    top_state_t                          state_reg, state_next;
    logic [swbm_pkg::FPS_W-1:0]          fps_reg;
    logic [swbm_pkg::CNT_W-1:0]          fps_eff;
    logic [swbm_pkg::CNT_W-1:0]          fps_cur_reg, fps_cur_next;
    logic [swbm_pkg::ADDR_W-1:0]         write_slot_reg, write_slot_next;
    logic [swbm_pkg::ADDR_W-1:0]         slot_eff;
    logic [swbm_pkg::CNT_W-1:0]          slot_inc;
    logic [swbm_pkg::COUNT_W-1:0]        frame_count_reg, frame_count_next;
    logic [swbm_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic [swbm_pkg::TOTAL_W:0]          total_sum;
    logic [swbm_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [swbm_pkg::CNT_W-1:0]          sw_cnt_reg, sw_cnt_next;
    logic                                rd_pend_reg, rd_pend_next;
    logic                                rd_valid_reg;
    logic [swbm_pkg::WINDOW_DEPTH-1:0]   valid_reg, valid_next;
    logic [swbm_pkg::RATE_W-1:0]         wrate_reg, wrate_next;
    logic [swbm_pkg::RATE_W-1:0]         grate_reg, grate_next;
    logic                                out_valid_reg, out_valid_next;
    logic [swbm_pkg::OUT_W-1:0]          out_data_reg, out_data_next;
    logic                                accept;
    logic                                ram_we;
    logic [swbm_pkg::ADDR_W-1:0]         ram_raddr;
    logic [swbm_pkg::SIZE_W-1:0]         ram_rdata;
    logic [swbm_pkg::SIZE_W-1:0]         ring_word;
    swbm_pkg::md_req_t                   md_req;
    swbm_pkg::md_rsp_t                   md_rsp;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == T_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // clamp fps to 1..window depth
    always_comb
    begin
        priority if (fps_reg == '0)
        begin
            fps_eff = swbm_pkg::CNT_W'(1);
        end
        else if (32'(fps_reg) > 32'(swbm_pkg::WINDOW_DEPTH))
        begin
            fps_eff = swbm_pkg::CNT_W'(swbm_pkg::WINDOW_DEPTH);
        end
        else
        begin
            fps_eff = swbm_pkg::CNT_W'(fps_reg);
        end
    end

    assign slot_eff  = (swbm_pkg::CNT_W'(write_slot_reg) >= fps_eff) ? '0 : write_slot_reg;
    assign slot_inc  = swbm_pkg::CNT_W'(slot_eff) + 1'b1;
    assign total_sum = {1'b0, total_reg} + (swbm_pkg::TOTAL_W + 1)'(s_axis_tdata);
    assign ram_we    = accept;
    assign ring_word = ram_rdata & {swbm_pkg::SIZE_W{rd_valid_reg}};

    swbm_ram #(
        .WIDTH(swbm_pkg::SIZE_W),
        .DEPTH(swbm_pkg::WINDOW_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(slot_eff),
        .wdata(s_axis_tdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    swbm_muldiv u_muldiv (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (md_req),
        .rsp  (md_rsp)
    );

    always_comb
    begin
        state_next       = state_reg;
        fps_cur_next     = fps_cur_reg;
        write_slot_next  = write_slot_reg;
        frame_count_next = frame_count_reg;
        total_next       = total_reg;
        sum_next         = sum_reg;
        sw_cnt_next      = sw_cnt_reg;
        rd_pend_next     = 1'b0;
        valid_next       = valid_reg;
        wrate_next       = wrate_reg;
        grate_next       = grate_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        ram_raddr        = '0;
        md_req.start     = 1'b0;
        md_req.operand   = swbm_pkg::TOTAL_W'(sum_reg);
        md_req.scale     = swbm_pkg::FPS_W'(1);
        md_req.divisor   = swbm_pkg::COUNT_W'(1);
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    fps_cur_next          = fps_eff;
                    valid_next[slot_eff]  = 1'b1;
                    write_slot_next       = (slot_inc == fps_eff) ? '0
                                          : slot_inc[swbm_pkg::ADDR_W-1:0];
                    if (frame_count_reg != swbm_pkg::COUNT_MAX)
                    begin
                        frame_count_next = frame_count_reg + 1'b1;
                    end
                    total_next  = total_sum[swbm_pkg::TOTAL_W] ? swbm_pkg::TOTAL_MAX
                                : total_sum[swbm_pkg::TOTAL_W-1:0];
                    sum_next    = '0;
                    sw_cnt_next = '0;
                    state_next  = T_SWEEP;
                end
            end
            T_SWEEP:
            begin
                // read slot sw_cnt, add the word read in the previous cycle
                if (sw_cnt_reg < fps_cur_reg)
                begin
                    ram_raddr    = sw_cnt_reg[swbm_pkg::ADDR_W-1:0];
                    rd_pend_next = 1'b1;
                    sw_cnt_next  = sw_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = T_WSTART;
                end
                if (rd_pend_reg)
                begin
                    sum_next = sum_reg + swbm_pkg::SUM_W'(ring_word);
                end
            end
            T_WSTART:
            begin
                md_req.start = 1'b1;
                if (frame_count_reg < swbm_pkg::COUNT_W'(fps_cur_reg))
                begin
                    md_req.scale   = swbm_pkg::FPS_W'(fps_cur_reg);
                    md_req.divisor = frame_count_reg;
                end
                state_next = T_WWAIT;
            end
            T_WWAIT:
            begin
                if (md_rsp.done)
                begin
                    wrate_next = md_rsp.quotient;
                    state_next = T_GSTART;
                end
            end
            T_GSTART:
            begin
                md_req.start   = 1'b1;
                md_req.operand = total_reg;
                md_req.scale   = swbm_pkg::FPS_W'(fps_cur_reg);
                md_req.divisor = frame_count_reg;
                state_next     = T_GWAIT;
            end
            T_GWAIT:
            begin
                if (md_rsp.done)
                begin
                    grate_next = md_rsp.quotient;
                    state_next = T_OUT;
                end
            end
            T_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, grate_reg, wrate_reg, frame_count_reg};
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_IDLE;
            fps_reg         <= swbm_pkg::FPS_RESET;
            write_slot_reg  <= '0;
            frame_count_reg <= '0;
            total_reg       <= '0;
            valid_reg       <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                fps_reg <= cfg_data;
            end
            write_slot_reg  <= write_slot_next;
            frame_count_reg <= frame_count_next;
            total_reg       <= total_next;
            valid_reg       <= valid_next;
            rd_pend_reg     <= rd_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fps_cur_reg  <= fps_cur_next;
        sum_reg      <= sum_next;
        sw_cnt_reg   <= sw_cnt_next;
        rd_valid_reg <= valid_reg[ram_raddr];
        wrate_reg    <= wrate_next;
        grate_reg    <= grate_next;
        out_data_reg <= out_data_next;
    end

    `SWBM_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready)
    `SWBM_ASSERT_IMP(a_load_from_out, $rose(m_axis_tvalid), $past(state_reg == T_OUT))
    `SWBM_ASSERT_IMP(a_md_done_waiting, md_rsp.done,
                     (state_reg == T_WWAIT) || (state_reg == T_GWAIT))
    `SWBM_ASSERT_IMP(a_frame_number_nonzero, m_axis_tvalid, m_axis_tdata[31:0] != 32'd0)

endmodule

`default_nettype wire

### sim/swbm_rate_monitor.sv
// bit-exact predictor and result comparator for the sliding window bitrate meter
// watches the config, frame and result channels; depends on swbm_pkg only
`timescale 1ns / 1ps

module swbm_rate_monitor
    import swbm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_data,       // frames_per_second
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // frame_size[23:0]
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [95:0] m_axis_tdata,   // frame_number[31:0], window_rate[62:32],
                                             // global_rate[93:63], zero[95:94]
    output int unsigned      mismatches,
    output int unsigned      outstanding,
    output int unsigned      checked
);

    // highest field first, so frame_number lands in the low bits
    typedef struct packed {
        logic [RATE_W-1:0]  global_rate;
        logic [RATE_W-1:0]  window_rate;
        logic [COUNT_W-1:0] frame_number;
    } meter_reading_t;

    logic [FPS_W-1:0]   fps_reg;
    logic [SIZE_W-1:0]  size_ring [WINDOW_DEPTH];
    int unsigned        ring_slot;
    logic [COUNT_W-1:0] frames_seen;
    logic [TOTAL_W-1:0] size_total;
    meter_reading_t     expected_readings [$];

    function void predict_reading(input logic [SIZE_W-1:0] size);
        int unsigned       fps;
        logic [63:0]       window_acc;
        logic [63:0]       window_rate;
        logic [63:0]       global_rate;
        logic [TOTAL_W:0]  total_next;
        meter_reading_t    reading;
        if (fps_reg == '0)
            fps = 1;
        else if (fps_reg > WINDOW_DEPTH)
            fps = WINDOW_DEPTH;
        else
            fps = fps_reg;
        if (ring_slot >= fps)
            ring_slot = 0;
        size_ring[ring_slot] = size;
        ring_slot = (ring_slot + 1 == fps) ? 0 : ring_slot + 1;
        if (frames_seen != COUNT_MAX)
            frames_seen = frames_seen + 1'b1;
        window_acc = '0;
        for (int i = 0; i < fps; i++)
            window_acc = window_acc + 64'(size_ring[i]);
        window_acc = 64'(window_acc[SUM_W-1:0]);
        // extrapolate while the window is still filling
        if (64'(frames_seen) < 64'(fps))
            window_rate = (window_acc * 64'(fps)) / 64'(frames_seen);
        else
            window_rate = window_acc;
        total_next = {1'b0, size_total} + (TOTAL_W + 1)'(size);
        size_total = (total_next > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_next[TOTAL_W-1:0];
        global_rate = (64'(size_total) * 64'(fps)) / 64'(frames_seen);
        reading.frame_number = frames_seen;
        reading.window_rate  = (window_rate > 64'(RATE_MAX)) ? RATE_MAX
                                                             : window_rate[RATE_W-1:0];
        reading.global_rate  = (global_rate > 64'(RATE_MAX)) ? RATE_MAX
                                                             : global_rate[RATE_W-1:0];
        expected_readings.push_back(reading);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        meter_reading_t want;
        meter_reading_t got;
        logic           bad;
        if (!rst_n)
        begin
            fps_reg = FPS_RESET;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                size_ring[i] = '0;
            ring_slot   = 0;
            frames_seen = '0;
            size_total  = '0;
            expected_readings.delete();
            mismatches  = 0;
            outstanding = 0;
            checked     = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[93:0];
                checked = checked + 1;
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: result transaction with no frame pending, got %h",
                             $time, m_axis_tdata);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    bad  = 1'b0;
                    if (got.frame_number !== want.frame_number)
                    begin
                        $display("%0t: frame_number expected %0d got %0d",
                                 $time, want.frame_number, got.frame_number);
                        bad = 1'b1;
                    end
                    if (got.window_rate !== want.window_rate)
                    begin
                        $display("%0t: window_rate of frame %0d expected %0d got %0d",
                                 $time, want.frame_number, want.window_rate, got.window_rate);
                        bad = 1'b1;
                    end
                    if (got.global_rate !== want.global_rate)
                    begin
                        $display("%0t: global_rate of frame %0d expected %0d got %0d",
                                 $time, want.frame_number, want.global_rate, got.global_rate);
                        bad = 1'b1;
                    end
                    if (m_axis_tdata[95:94] !== 2'b00)
                    begin
                        $display("%0t: padding bits expected 0 got %b",
                                 $time, m_axis_tdata[95:94]);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches = mismatches + 1;
                end
            end
            if (cfg_valid && cfg_ready)
                fps_reg = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_reading(s_axis_tdata);
            outstanding = expected_readings.size();
        end
    end

endmodule

### sim/sliding_window_bitrate_meter_unit_test.sv
// top of the sliding window bitrate meter testbench: clock, reset, frame and
// config stimulus, result back-pressure and verdict; checking is in swbm_rate_monitor
`timescale 1ns / 1ps

module sliding_window_bitrate_meter_unit_test;

    import swbm_pkg::*;

    localparam int RANDOM_FRAMES = 2000;
    localparam int SETTLE_CYCLES = 256;
    localparam int HOLD_CYCLES   = 1500;
    localparam int STEADY_PHASE  = 2;
    localparam int HOLD_PHASE    = 5;

    localparam logic [SIZE_W-1:0] CORNER_SIZES [0:13] = '{
        24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555, 24'h000001, 24'h800000,
        24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h123456, 24'hFEDCBA,
        24'h0000FF, 24'hFFFF00
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [FPS_W-1:0]  cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [SIZE_W-1:0] s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [95:0]       m_axis_tdata;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned checked;

    int unsigned frames_sent = 0;
    int unsigned fps_settings = 0;
    bit          steady = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned hold_left = 0;

    always #5 clk = ~clk;

    sliding_window_bitrate_meter_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    swbm_rate_monitor u_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .checked       (checked)
    );

    // result side back-pressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left     = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 24);
        end
    end

    initial
    begin
        #50_000_000;
        $display("sliding_window_bitrate_meter_unit verification failed");
        $finish;
    end

    task automatic send_frame(input logic [SIZE_W-1:0] size);
        if (!steady)
            while ($urandom_range(0, 99) < 24)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= size;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        frames_sent = frames_sent + 1;
    endtask

    task automatic write_fps(input logic [FPS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        fps_settings = fps_settings + 1;
    endtask

    // stop offering frames until every reading is back and the block is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int unsigned       random_sent;
        int unsigned       phase;
        int unsigned       phase_frames;
        logic [FPS_W-1:0]  fps_value;
        logic [SIZE_W-1:0] size;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset fps: window still filling, extreme and alternating sizes
        foreach (CORNER_SIZES[i])
            send_frame(CORNER_SIZES[i]);
        drain();
        // zero register acts as one frame per second
        write_fps('0);
        send_frame(24'hFFFFFF);
        send_frame(24'h000000);
        send_frame(24'h5A5A5A);
        drain();
        // above the ring depth clamps to 128, stale ring entries count again
        write_fps('1);
        send_frame(24'hFFFFFF);
        send_frame(24'hFFFFFF);
        send_frame(24'h000000);
        send_frame(24'h3C3C3C);
        drain();

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_FRAMES)
        begin
            case (phase)
                0:       fps_value = 8'd128;
                1:       fps_value = 8'd1;
                2:       fps_value = 8'd16;
                3:       fps_value = 8'd255;
                4:       fps_value = 8'd0;
                default: fps_value = ($urandom_range(0, 3) == 0) ? FPS_W'($urandom_range(0, 255))
                                                                 : FPS_W'($urandom_range(1, 16));
            endcase
            write_fps(fps_value);
            steady = (phase == STEADY_PHASE);
            if (phase == HOLD_PHASE)
                hold_request = 1'b1;
            phase_frames = (fps_value > 8'd32) ? 100 : 200;
            repeat (phase_frames)
            begin
                case ($urandom_range(0, 9))
                    0:       size = '0;
                    1:       size = '1;
                    2, 3, 4: size = SIZE_W'($urandom_range(0, 255));
                    default: size = SIZE_W'($urandom);
                endcase
                send_frame(size);
                random_sent = random_sent + 1;
            end
            drain();
            steady = 1'b0;
            phase  = phase + 1;
        end

        $display("run covered %0d frames under %0d fps settings, %0d readings compared",
                 frames_sent, fps_settings, checked);
        $display("including window fill, clamped fps, mid-stream fps changes and a long stall");
        if (mismatches == 0 && outstanding == 0)
            $display("sliding_window_bitrate_meter_unit verification clean");
        else
            $display("sliding_window_bitrate_meter_unit verification failed");
        $finish;
    end

endmodule
